// ===== src/hsc_pkg.sv =====
// shared types, constants and helper functions for the secded encoder and checker
package hsc_pkg;

    localparam int MAX_BLOCK_BITS = 32;
    localparam int MAX_DATA_BITS  = 26;
    localparam int LEN_W          = 5;
    localparam int POS_W          = 5;
    localparam int SYN_W          = 5;
    localparam int CODE_W         = 2;

    localparam logic [LEN_W-1:0] LEN_BLK16 = LEN_W'(5);
    localparam logic [LEN_W-1:0] LEN_BLK32 = LEN_W'(12);

    typedef enum logic [CODE_W-1:0] {
        BLK_8  = 2'd0,
        BLK_16 = 2'd1,
        BLK_32 = 2'd2
    } t_blk_code;

    typedef struct packed {
        logic [MAX_DATA_BITS-1:0] data_bits;
        logic [LEN_W-1:0]         data_length;
        logic                     inject_error;
        logic [POS_W-1:0]         error_position;
    } t_in_beat;

    typedef struct packed {
        logic [MAX_BLOCK_BITS-1:0] codeword;
        logic [MAX_BLOCK_BITS-1:0] received;
        logic [CODE_W-1:0]         block_size_code;
        logic [SYN_W-1:0]          syndrome;
        logic                      overall_parity;
        logic                      error_found;
    } t_out_beat;

    typedef struct packed {
        logic [MAX_BLOCK_BITS-1:0] word;
        logic [MAX_BLOCK_BITS-1:0] flip;
        t_blk_code                 code;
    } t_place_beat;

    typedef struct packed {
        logic [MAX_BLOCK_BITS-1:0] codeword;
        logic [MAX_BLOCK_BITS-1:0] received;
        t_blk_code                 code;
    } t_enc_beat;

    // codeword position of the idx-th data bit
    function automatic logic [POS_W-1:0] data_pos(input int idx);
        int               cnt;
        logic [POS_W-1:0] res;
        cnt = 0;
        res = '0;
        for (int p = 1; p < MAX_BLOCK_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == idx) begin
                    res = POS_W'(p);
                end
                cnt++;
            end
        end
        return res;
    endfunction

    // positions whose index has bit j set
    function automatic logic [MAX_BLOCK_BITS-1:0] sel_mask(input int j);
        logic [MAX_BLOCK_BITS-1:0] m;
        m = '0;
        for (int p = 0; p < MAX_BLOCK_BITS; p++) begin
            m[p] = ((p >> j) & 1) != 0;
        end
        return m;
    endfunction

    function automatic logic in_block(input logic [POS_W-1:0] pos, input t_blk_code code);
        logic res;
        case (code)
            BLK_8:   res = (pos[POS_W-1:3] == '0);
            BLK_16:  res = (pos[POS_W-1:4] == '0);
            BLK_32:  res = 1'b1;
            default: res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

// ===== src/hsc_place.sv =====
// first stage: block size selection, data placement and flip mask
module hsc_place import hsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_beat    i_beat,
    output logic        o_valid,
    input  logic        i_stall,
    output t_place_beat o_beat
);

    logic        r_valid;
    t_place_beat r_beat;
    t_place_beat n_beat;
    t_blk_code   code;
    logic        flip_en;

    always_comb begin
        if (i_beat.data_length < LEN_BLK16) begin
            code = BLK_8;
        end else if (i_beat.data_length < LEN_BLK32) begin
            code = BLK_16;
        end else begin
            code = BLK_32;
        end
    end

    always_comb begin
        n_beat      = '0;
        n_beat.code = code;
        for (int k = 0; k < MAX_DATA_BITS; k++) begin
            if (i_beat.data_bits[k] && (LEN_W'(k) < i_beat.data_length)
                && in_block(data_pos(k), code)) begin
                n_beat.word[data_pos(k)] = 1'b1;
            end
        end
        flip_en = i_beat.inject_error && in_block(i_beat.error_position, code);
        if (flip_en) begin
            n_beat.flip[i_beat.error_position] = 1'b1;
        end
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== src/hsc_encode.sv =====
// second stage: hamming and overall parity, error flip
module hsc_encode import hsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_place_beat i_beat,
    output logic        o_valid,
    input  logic        i_stall,
    output t_enc_beat   o_beat
);

    logic                      r_valid;
    t_enc_beat                 r_beat;
    t_enc_beat                 n_beat;
    logic [MAX_BLOCK_BITS-1:0] cw;

    always_comb begin
        cw = i_beat.word;
        for (int j = 0; j < SYN_W; j++) begin
            cw[1 << j] = ^(i_beat.word & sel_mask(j));
        end
        cw[0]           = ^cw[MAX_BLOCK_BITS-1:1];
        n_beat.codeword = cw;
        n_beat.received = cw ^ i_beat.flip;
        n_beat.code     = i_beat.code;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== src/hsc_check.sv =====
// third stage: syndrome, overall parity and error flag of the received word
module hsc_check import hsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_enc_beat i_beat,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_beat
);

    logic             r_valid;
    t_out_beat        r_beat;
    t_out_beat        n_beat;
    logic [SYN_W-1:0] syn;

    always_comb begin
        for (int j = 0; j < SYN_W; j++) begin
            syn[j] = ^(i_beat.received & sel_mask(j));
        end
        n_beat.codeword        = i_beat.codeword;
        n_beat.received        = i_beat.received;
        n_beat.block_size_code = i_beat.code;
        n_beat.syndrome        = syn;
        n_beat.overall_parity  = ^i_beat.received;
        n_beat.error_found     = |syn;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== src/hamming_secded_encode_check.sv =====
// top level of the extended hamming secded encoder and checker
// Takes one beat per clock while o_in_stall is low and returns one result
// beat per input beat. The work is split over three register stages: data
// placement and block size, parity generation with the optional single-bit
// flip, and the syndrome and parity check of the received word; the last
// stage register is the output. Each stage holds its beat while the next
// one stalls and fills bubbles, so a stall loses nothing and a full
// pipeline holds three beats. There is no stored state beyond the pipeline
// and no configuration.
module hamming_secded_encode_check import hsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic        place_valid;
    logic        place_stall;
    t_place_beat place_beat;
    logic        enc_valid;
    logic        enc_stall;
    t_enc_beat   enc_beat;

    hsc_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_beat  (i_in_beat),
        .o_valid (place_valid),
        .i_stall (place_stall),
        .o_beat  (place_beat)
    );

    hsc_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (place_valid),
        .o_stall (place_stall),
        .i_beat  (place_beat),
        .o_valid (enc_valid),
        .i_stall (enc_stall),
        .o_beat  (enc_beat)
    );

    hsc_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (enc_valid),
        .o_stall (enc_stall),
        .i_beat  (enc_beat),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_beat)
    );

`ifndef SYNTHESIS
    a_flag_matches_syndrome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.error_found == (o_out_beat.syndrome != '0)))
        else $error("error flag disagrees with syndrome");

    a_parity_marks_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.overall_parity
                         == (o_out_beat.received != o_out_beat.codeword)))
        else $error("overall parity does not reflect the flip");

    a_clean_word_zero_syndrome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.received == o_out_beat.codeword))
        |-> (o_out_beat.syndrome == '0))
        else $error("unflipped codeword has nonzero syndrome");

    a_small_block_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.block_size_code == BLK_8))
        |-> (o_out_beat.received[MAX_BLOCK_BITS-1:8] == '0))
        else $error("bits above the 8-bit block are set");
`endif

endmodule

// ===== verif/hsc_scoreboard.sv =====
// scoreboard for the secded encoder and checker: predicts each result beat and compares it
module hsc_scoreboard import hsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked,
    output int        o_flips
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out_beat want_words[$];
    int        fails   = 0;
    int        checked = 0;
    int        flips   = 0;
    int        pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_flips      = flips;

    function automatic logic [SYN_W-1:0] position_xor(input logic [MAX_BLOCK_BITS-1:0] w,
                                                      input int nbits);
        logic [SYN_W-1:0] acc;
        acc = '0;
        for (int p = 1; p < nbits; p++) begin
            if (w[p]) begin
                acc = acc ^ SYN_W'(p);
            end
        end
        return acc;
    endfunction

    function automatic t_out_beat encode_and_check(input t_in_beat b);
        t_out_beat                 res;
        logic [MAX_BLOCK_BITS-1:0] cw;
        logic [MAX_BLOCK_BITS-1:0] rx;
        logic [MAX_DATA_BITS-1:0]  data;
        logic [SYN_W-1:0]          syn;
        t_blk_code                 blk;
        int                        nbits;
        int                        nlen;
        int                        k;
        nlen = (int'(b.data_length) > MAX_DATA_BITS) ? MAX_DATA_BITS : int'(b.data_length);
        data = b.data_bits;
        for (int i = 0; i < MAX_DATA_BITS; i++) begin
            if (i >= nlen) begin
                data[i] = 1'b0;
            end
        end
        if (b.data_length < LEN_BLK16) begin
            blk   = BLK_8;
            nbits = 8;
        end else if (b.data_length < LEN_BLK32) begin
            blk   = BLK_16;
            nbits = 16;
        end else begin
            blk   = BLK_32;
            nbits = 32;
        end
        cw = '0;
        k  = 0;
        for (int p = 1; p < MAX_BLOCK_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (p < nbits && data[k]) begin
                    cw[p] = 1'b1;
                end
                k++;
            end
        end
        syn = position_xor(cw, nbits);
        for (int j = 0; j < SYN_W; j++) begin
            if ((1 << j) < nbits && syn[j]) begin
                cw[1 << j] = 1'b1;
            end
        end
        cw[0] = ^cw;
        rx = cw;
        if (b.inject_error && int'(b.error_position) < nbits) begin
            rx[b.error_position] = ~rx[b.error_position];
        end
        syn = position_xor(rx, nbits);
        res.codeword        = cw;
        res.received        = rx;
        res.block_size_code = blk;
        res.syndrome        = syn;
        res.overall_parity  = ^rx;
        res.error_found     = (syn != '0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fails++;
        if (fails <= 40) begin
            $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        t_out_beat pred;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (want_words.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    i_out_beat.codeword, '0);
                end else begin
                    want = want_words.pop_front();
                    checked++;
                    if (i_out_beat.codeword !== want.codeword)
                        report_mismatch("codeword", i_out_beat.codeword, want.codeword);
                    if (i_out_beat.received !== want.received)
                        report_mismatch("received", i_out_beat.received, want.received);
                    if (i_out_beat.block_size_code !== want.block_size_code)
                        report_mismatch("block_size_code", 32'(i_out_beat.block_size_code),
                                        32'(want.block_size_code));
                    if (i_out_beat.syndrome !== want.syndrome)
                        report_mismatch("syndrome", 32'(i_out_beat.syndrome),
                                        32'(want.syndrome));
                    if (i_out_beat.overall_parity !== want.overall_parity)
                        report_mismatch("overall_parity", 32'(i_out_beat.overall_parity),
                                        32'(want.overall_parity));
                    if (i_out_beat.error_found !== want.error_found)
                        report_mismatch("error_found", 32'(i_out_beat.error_found),
                                        32'(want.error_found));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pred = encode_and_check(i_in_beat);
                if (pred.received != pred.codeword) begin
                    flips++;
                end
                want_words.push_back(pred);
            end
            pending <= want_words.size();
        end
    end

endmodule

// ===== verif/tb_hamming_secded_encode_check.sv =====
// testbench top for the secded encoder and checker: stimulus, output stalls and verdict
module tb_hamming_secded_encode_check;
    import hsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_BEATS = 1030;
    localparam int HOLD_CYCLES = 64;
    localparam logic [MAX_DATA_BITS-1:0] ALL_ONES = '1;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;
    int        fail_count;
    int        pending;
    int        checked;
    int        flips;
    int        sent;
    int        rand_sent;
    int        burst;
    int        gap;
    int        holdoffs;

    hamming_secded_encode_check i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    hsc_scoreboard i_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flips      (flips)
    );

    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_in_beat make_beat(input logic [MAX_DATA_BITS-1:0] data,
                                           input int len, input logic inj, input int pos);
        t_in_beat b;
        b.data_bits      = data;
        b.data_length    = LEN_W'(len);
        b.inject_error   = inj;
        b.error_position = POS_W'(pos);
        return b;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input t_in_beat b);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        sent++;
        @(negedge clk);
    endtask

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : receiver
        int cyc;
        int mode;
        cyc       = 0;
        holdoffs  = 0;
        out_stall = 1'b0;
        do @(negedge clk); while (!rst_n);
        forever begin
            if (cyc == 400 || cyc == 1500) begin
                // long hold-off so the pipeline fills and stalls its input
                out_stall <= 1'b1;
                holdoffs++;
                repeat (HOLD_CYCLES) @(negedge clk);
                cyc += HOLD_CYCLES;
            end else begin
                mode = (cyc / 97) % 4;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= (cyc % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 2) != 0);
                endcase
                @(negedge clk);
                cyc++;
            end
        end
    end

    initial begin : sender
        t_in_beat b;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        sent      = 0;
        rand_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_beat(make_beat(ALL_ONES, 0, 1'b0, 0));
        send_beat(make_beat('0, 0, 1'b0, 0));
        send_beat(make_beat(ALL_ONES, 4, 1'b1, 7));
        send_beat(make_beat(ALL_ONES, 4, 1'b1, 8));
        send_beat(make_beat(ALL_ONES, 4, 1'b1, 0));
        send_beat(make_beat(26'h3FFFFF8, 3, 1'b1, 3));
        send_beat(make_beat(ALL_ONES, 5, 1'b1, 15));
        send_beat(make_beat(ALL_ONES, 5, 1'b1, 16));
        send_beat(make_beat(ALL_ONES, 11, 1'b1, 1));
        send_beat(make_beat(ALL_ONES, 12, 1'b1, 31));
        send_beat(make_beat(ALL_ONES, 26, 1'b1, 16));
        send_beat(make_beat(ALL_ONES, 26, 1'b0, 31));
        send_beat(make_beat(ALL_ONES, 27, 1'b1, 2));
        send_beat(make_beat(ALL_ONES, 31, 1'b1, 4));
        send_beat(make_beat(26'h2AAAAAA, 20, 1'b1, 8));
        send_beat(make_beat(26'h1555555, 18, 1'b1, 0));
        send_beat(make_beat('0, 31, 1'b1, 31));
        send_beat(make_beat(ALL_ONES, 1, 1'b1, 5));
        in_valid <= 1'b0;
        repeat (3) @(negedge clk);

        while (rand_sent < RAND_BEATS) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && rand_sent < RAND_BEATS; i++) begin
                b.data_bits = MAX_DATA_BITS'($urandom);
                case ($urandom_range(0, 3))
                    0: b.data_length = LEN_W'($urandom_range(0, 4));
                    1: b.data_length = LEN_W'($urandom_range(5, 11));
                    2: b.data_length = LEN_W'($urandom_range(12, 26));
                    default: b.data_length = LEN_W'($urandom_range(0, 31));
                endcase
                b.inject_error   = 1'($urandom_range(0, 1));
                b.error_position = POS_W'($urandom_range(0, 31));
                send_beat(b);
                rand_sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);

        $display("covered %0d input beats over 8, 16 and 32 bit blocks, %0d results checked",
                 sent, checked);
        $display("%0d beats had a bit flipped inside the block, %0d long output hold-offs",
                 flips, holdoffs);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
